// ----- hdl/tchm_pkg.sv -----
// Shared types, codes and constants of the tagger channel hit merger.
package tchm_pkg;

  // default array sizes
  localparam int CHANNELS_DEF = 128;
  localparam int HITS_DEF     = 16;

  // stream widths
  localparam int IN_TDATA_W  = 144;
  localparam int OUT_TDATA_W = 152;
  localparam int KIND_W      = 2;

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_ADDR_W-1:0] REG_BUCKET_PERIOD = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TWO_HIT_RES   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_HIT_DEPOSIT   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_HITS      = 2'd3;

  localparam logic [19:0] BUCKET_PERIOD_RST = 20'd4000;
  localparam logic [19:0] TWO_HIT_RES_RST   = 20'd25000;
  localparam logic [16:0] HIT_DEPOSIT_RST   = 17'd3500;
  localparam logic [4:0]  MAX_HITS_RST      = 5'd16;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_PHOTON = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

  // result actions
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_MERGE  = 2'd2;
  localparam logic [1:0] ACT_DROP   = 2'd3;

  // shared divider sizes: numerator covers CHANNELS * 24-bit span and 2t+p
  localparam int DIV_NW = 34;
  localparam int DIV_DW = 24;
  localparam int DIV_CW = 6;

  typedef struct packed {
    logic [9:0]  label;
    logic [23:0] high;
    logic [23:0] low;
  } tbl_ent_t;

  typedef struct packed {
    logic [15:0]        bg;
    logic [31:0]        dep;
    logic [23:0]        energy;
    logic signed [31:0] time_ps;
  } hit_rec_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [6:0]         slot;
    logic [9:0]         label;
    logic [23:0]        center;
    logic [4:0]         hits;
    logic               rvalid;
    logic signed [31:0] rtime;
    logic [23:0]        renergy;
    logic [31:0]        rdep;
    logic [15:0]        rbg;
  } res_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // midpoint of a channel window
  function automatic logic [23:0] win_center(logic [23:0] lo, logic [23:0] hi);
    logic [24:0] s;
    s = {1'b0, lo} + {1'b0, hi};
    return s[24:1];
  endfunction

endpackage

// ----- hdl/tchm_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
module tchm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tchm_pkg::DIV_NW-1:0] num,
  input  logic [tchm_pkg::DIV_DW-1:0] den,
  output tchm_pkg::div_stat_t        stat,
  output logic [tchm_pkg::DIV_NW-1:0] quot
);
  import tchm_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_NW-1:0] quo_r, quo_nxt;
  logic [DIV_DW-1:0] den_r, den_nxt;
  logic [DIV_DW:0]   rem_s;

  // shift one numerator bit into the remainder and try a subtract
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    rem_s    = {rem_r, quo_r[DIV_NW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CW'(DIV_NW);
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      if (rem_s >= {1'b0, den_r}) begin
        rem_nxt = DIV_DW'(rem_s - {1'b0, den_r});
        quo_nxt = {quo_r[DIV_NW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_s[DIV_DW-1:0];
        quo_nxt = {quo_r[DIV_NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = quo_r;

  // a start never lands on a running division
  assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("divider restarted while busy");
  // done follows the last step only
  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r && $past(busy_r))
    else $error("divider done without a running division");
  // a divisor of zero never reaches the unit
  assert property (@(posedge clk) disable iff (!rst_n) start |-> den != '0)
    else $error("divide by zero");

endmodule

// ----- hdl/tagger_channel_hit_merger_core.sv -----
// Top level: channel window lookup and per-channel time-sorted hit lists.
//
//  channel | dir | payload                                   | handshake
//  cfg_*   | in  | 4 registers, index cfg_addr, cfg_wdata    | cfg_wr_en only
//  in_*    | in  | tuser kind, tdata photon/load/read fields | tvalid/tready
//  out_*   | out | tuser action, tdata entry and hit fields  | tvalid/tready
//
// A photon uses the shared divider twice (guess, then bucket rounding), then
// walks the window table, scans the hit list and, on insert, moves each later
// hit up by one. Reset: a clearing pass zeroes window table and counts;
// in_tready stays low during it. One item is worked at a time; the output
// register lets the next item enter while the last result waits.
module tagger_channel_hit_merger_core #(
  parameter int CHANNELS         = tchm_pkg::CHANNELS_DEF,
  parameter int HITS_PER_CHANNEL = tchm_pkg::HITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [tchm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [tchm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // photon_energy_kev[23:0] photon_time_ps[55:24] background_tag[71:56]
  // table_slot[78:72] hit_slot[82:79] channel_label[92:83]
  // window_low_kev[116:93] window_high_kev[140:117]
  input  logic [tchm_pkg::IN_TDATA_W-1:0]   in_tdata,
  // kind[1:0]
  input  logic [tchm_pkg::KIND_W-1:0]       in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // matched_slot[6:0] matched_label[16:7] center_energy_kev[40:17]
  // hits_in_channel[45:41] read_valid[46] read_time_ps[78:47]
  // read_energy_kev[102:79] read_deposit_kev[134:103] read_background[150:135]
  output logic [tchm_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // action[1:0]
  output logic [1:0]                        out_tuser
);
  import tchm_pkg::*;

  localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int HIW = $clog2(HITS_PER_CHANNEL + 1);
  localparam int AW  = (CHANNELS * HITS_PER_CHANNEL > 1) ?
                       $clog2(CHANNELS * HITS_PER_CHANNEL) : 1;

  localparam logic [4:0] S_INIT = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_LOAD = 5'd2;
  localparam logic [4:0] S_RD1  = 5'd3;
  localparam logic [4:0] S_RD2  = 5'd4;
  localparam logic [4:0] S_CLR  = 5'd5;
  localparam logic [4:0] S_GDIV = 5'd6;
  localparam logic [4:0] S_WUP  = 5'd7;
  localparam logic [4:0] S_WDN  = 5'd8;
  localparam logic [4:0] S_TDIV = 5'd9;
  localparam logic [4:0] S_TMUL = 5'd10;
  localparam logic [4:0] S_TSAT = 5'd11;
  localparam logic [4:0] S_SCAN = 5'd12;
  localparam logic [4:0] S_INS  = 5'd13;
  localparam logic [4:0] S_SHR  = 5'd14;
  localparam logic [4:0] S_SHW  = 5'd15;
  localparam logic [4:0] S_DONE = 5'd16;

  function automatic logic [AW-1:0] hit_addr(logic [CW-1:0] c, logic [HIW-1:0] h);
    return AW'(32'(c) * HITS_PER_CHANNEL + 32'(h));
  endfunction

  // input fields
  logic [23:0]        in_e;
  logic signed [31:0] in_t;
  logic [15:0]        in_bg;
  logic [6:0]         in_slot;
  logic [3:0]         in_hs;
  logic [9:0]         in_label;
  logic [23:0]        in_lo;
  logic [23:0]        in_hi;

  assign in_e     = in_tdata[23:0];
  assign in_t     = in_tdata[55:24];
  assign in_bg    = in_tdata[71:56];
  assign in_slot  = in_tdata[78:72];
  assign in_hs    = in_tdata[82:79];
  assign in_label = in_tdata[92:83];
  assign in_lo    = in_tdata[116:93];
  assign in_hi    = in_tdata[140:117];

  // configuration registers
  logic [19:0] period_r;
  logic [19:0] res_ps_r;
  logic [16:0] dep_kev_r;
  logic [4:0]  max_hits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r   <= BUCKET_PERIOD_RST;
      res_ps_r   <= TWO_HIT_RES_RST;
      dep_kev_r  <= HIT_DEPOSIT_RST;
      max_hits_r <= MAX_HITS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_BUCKET_PERIOD: period_r   <= cfg_wdata;
        REG_TWO_HIT_RES:   res_ps_r   <= cfg_wdata;
        REG_HIT_DEPOSIT:   dep_kev_r  <= cfg_wdata[16:0];
        REG_MAX_HITS:      max_hits_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // state registers
  logic [4:0]          state_r, state_nxt;
  logic [CW-1:0]       ch_r, ch_nxt;
  logic [23:0]         e_r, e_nxt;
  logic signed [31:0]  t_in_r, t_in_nxt;
  logic [15:0]         bg_r, bg_nxt;
  logic [3:0]          hs_r, hs_nxt;
  logic [23:0]         top_r, top_nxt;
  logic [23:0]         bot_r, bot_nxt;
  logic [HIW-1:0]      hidx_r, hidx_nxt;
  logic [HIW-1:0]      kidx_r, kidx_nxt;
  logic                neg_r, neg_nxt;
  logic signed [34:0]  tq_r, tq_nxt;
  logic signed [55:0]  prod_r, prod_nxt;
  logic signed [31:0]  tr_r, tr_nxt;
  res_t                res_r, res_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [1:0]          out_tuser_r, out_tuser_nxt;

  // memories
  tbl_ent_t       tbl_mem [CHANNELS];
  logic [HIW-1:0] cnt_mem [CHANNELS];
  hit_rec_t       hit_mem [CHANNELS * HITS_PER_CHANNEL];

  tbl_ent_t       tbl_q, tbl_wd;
  logic           tbl_we;
  logic [CW-1:0]  tbl_wa;
  logic [HIW-1:0] cnt_q, cnt_wd;
  logic           cnt_we;
  logic [CW-1:0]  cnt_wa;
  hit_rec_t       hit_q, hit_wd;
  logic           hit_we;
  logic [AW-1:0]  hit_wa, hit_ra;

  // divider
  logic              div_start;
  logic [DIV_NW-1:0] div_num, div_quot;
  logic [DIV_DW-1:0] div_den;
  div_stat_t         div_stat;

  tchm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  // helper values
  logic [20:0]        p_eff;
  logic signed [33:0] tn;
  logic [33:0]        tmag;
  logic signed [32:0] tdiff;
  logic [32:0]        tabs;
  logic [32:0]        dep_sum;
  logic [7:0]         lim;
  logic               slot_ok;
  hit_rec_t           merged;
  hit_rec_t           new_hit;

  always_comb begin
    p_eff   = (period_r == '0) ? 21'd1 : {1'b0, period_r};
    tn      = $signed({t_in_r[31], t_in_r, 1'b0}) + $signed({13'd0, p_eff});
    tmag    = tn[33] ? 34'(-tn + $signed({12'd0, p_eff, 1'b0}) - 34'sd1) : 34'(tn);
    tdiff   = $signed({tr_r[31], tr_r}) - $signed({hit_q.time_ps[31], hit_q.time_ps});
    tabs    = tdiff[32] ? 33'(-tdiff) : 33'(tdiff);
    dep_sum = {1'b0, hit_q.dep} + {16'd0, dep_kev_r};
    lim     = (max_hits_r < 5'(HITS_PER_CHANNEL > 31 ? 31 : HITS_PER_CHANNEL) ||
               HITS_PER_CHANNEL > 31) &&
              (32'(max_hits_r) < HITS_PER_CHANNEL) ? {3'd0, max_hits_r}
                                                     : 8'(HITS_PER_CHANNEL);
    slot_ok = 32'(in_slot) < CHANNELS;
    merged  = hit_q;
    if (tr_r < hit_q.time_ps) begin
      merged.time_ps = tr_r;
      merged.energy  = e_r;
      merged.bg      = bg_r;
    end
    merged.dep       = dep_sum[32] ? 32'hFFFF_FFFF : dep_sum[31:0];
    new_hit.time_ps  = tr_r;
    new_hit.energy   = e_r;
    new_hit.dep      = {15'd0, dep_kev_r};
    new_hit.bg       = bg_r;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    e_nxt     = e_r;
    t_in_nxt  = t_in_r;
    bg_nxt    = bg_r;
    hs_nxt    = hs_r;
    top_nxt   = top_r;
    bot_nxt   = bot_r;
    hidx_nxt  = hidx_r;
    kidx_nxt  = kidx_r;
    neg_nxt   = neg_r;
    tq_nxt    = tq_r;
    prod_nxt  = prod_r;
    tr_nxt    = tr_r;
    res_nxt   = res_r;
    tbl_we    = 1'b0;
    tbl_wa    = ch_r;
    tbl_wd    = '0;
    cnt_we    = 1'b0;
    cnt_wa    = ch_r;
    cnt_wd    = '0;
    hit_we    = 1'b0;
    hit_wa    = hit_addr(ch_r, hidx_r);
    hit_wd    = new_hit;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;

    case (state_r)
      // zero window table and hit counts after reset
      S_INIT: begin
        tbl_we = 1'b1;
        cnt_we = 1'b1;
        if (ch_r == CW'(CHANNELS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          ch_nxt = ch_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_tvalid) begin
          e_nxt    = in_e;
          t_in_nxt = in_t;
          bg_nxt   = in_bg;
          hs_nxt   = in_hs;
          res_nxt  = '0;
          state_nxt = S_DONE;
          case (in_tuser)
            KIND_PHOTON: begin
              if (in_e > bot_r && in_e < top_r) begin
                div_start = 1'b1;
                div_num   = DIV_NW'(CHANNELS) * DIV_NW'(top_r - in_e);
                div_den   = top_r - bot_r;
                state_nxt = S_GDIV;
              end
            end
            KIND_LOAD: begin
              if (slot_ok) begin
                tbl_we       = 1'b1;
                tbl_wa       = CW'(in_slot);
                tbl_wd.label = in_label;
                tbl_wd.low   = in_lo;
                tbl_wd.high  = in_hi;
                if (in_lo != '0 && in_hi != '0) begin
                  if (in_hi > top_r) top_nxt = in_hi;
                  if (in_lo < bot_r) bot_nxt = in_lo;
                end
                ch_nxt         = CW'(in_slot);
                res_nxt.slot   = in_slot;
                res_nxt.label  = in_label;
                res_nxt.center = win_center(in_lo, in_hi);
                state_nxt      = S_LOAD;
              end
            end
            KIND_READ: begin
              if (slot_ok) begin
                ch_nxt    = CW'(in_slot);
                state_nxt = S_RD1;
              end
            end
            default: begin
              ch_nxt    = '0;
              state_nxt = S_CLR;
            end
          endcase
        end
      end

      S_LOAD: begin
        res_nxt.hits = 5'(cnt_q);
        state_nxt    = S_DONE;
      end

      S_RD1: begin
        res_nxt.slot   = 7'(ch_r);
        res_nxt.label  = tbl_q.label;
        res_nxt.center = win_center(tbl_q.low, tbl_q.high);
        res_nxt.hits   = 5'(cnt_q);
        if (32'(hs_r) < HITS_PER_CHANNEL && 32'(hs_r) < 32'(cnt_q)) begin
          hidx_nxt  = HIW'(hs_r);
          state_nxt = S_RD2;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_RD2: begin
        res_nxt.rvalid  = 1'b1;
        res_nxt.rtime   = hit_q.time_ps;
        res_nxt.renergy = hit_q.energy;
        res_nxt.rdep    = hit_q.dep;
        res_nxt.rbg     = hit_q.bg;
        state_nxt       = S_DONE;
      end

      // empty all hit lists
      S_CLR: begin
        cnt_we = 1'b1;
        if (ch_r == CW'(CHANNELS - 1)) begin
          state_nxt = S_DONE;
        end else begin
          ch_nxt = ch_r + 1'b1;
        end
      end

      // interpolated first guess
      S_GDIV: begin
        if (div_stat.done) begin
          ch_nxt    = CW'(div_quot);
          state_nxt = S_WUP;
        end
      end

      // walk up past unused windows and windows above the energy
      S_WUP: begin
        if (e_r < tbl_q.low || tbl_q.low == '0) begin
          if (ch_r == CW'(CHANNELS - 1)) begin
            state_nxt = S_DONE;
          end else begin
            ch_nxt = ch_r + 1'b1;
          end
        end else begin
          state_nxt = S_WDN;
        end
      end

      // walk down past unused windows and windows below the energy
      S_WDN: begin
        if (e_r > tbl_q.high || tbl_q.high == '0) begin
          if (ch_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            ch_nxt = ch_r - 1'b1;
          end
        end else if (e_r >= tbl_q.low) begin
          res_nxt.slot   = 7'(ch_r);
          res_nxt.label  = tbl_q.label;
          res_nxt.center = win_center(tbl_q.low, tbl_q.high);
          div_start      = 1'b1;
          div_num        = tmag;
          div_den        = DIV_DW'({p_eff, 1'b0});
          neg_nxt        = tn[33];
          state_nxt      = S_TDIV;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // bucket rounding: floor((2t + p) / 2p) * p, saturated
      S_TDIV: begin
        if (div_stat.done) begin
          tq_nxt    = neg_r ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
          state_nxt = S_TMUL;
        end
      end

      S_TMUL: begin
        prod_nxt  = 56'(tq_r * $signed({1'b0, p_eff}));
        state_nxt = S_TSAT;
      end

      S_TSAT: begin
        if (prod_r > 56'sd2147483647) begin
          tr_nxt = 32'sh7FFF_FFFF;
        end else if (prod_r < -56'sd2147483648) begin
          tr_nxt = 32'sh8000_0000;
        end else begin
          tr_nxt = prod_r[31:0];
        end
        hidx_nxt  = '0;
        state_nxt = S_SCAN;
      end

      // scan the sorted list: merge, or find the insert position
      S_SCAN: begin
        if (hidx_r >= cnt_q) begin
          state_nxt = S_INS;
        end else if (tabs < {13'd0, res_ps_r}) begin
          hit_we         = 1'b1;
          hit_wd         = merged;
          res_nxt.action = ACT_MERGE;
          res_nxt.hits   = 5'(cnt_q);
          state_nxt      = S_DONE;
        end else if (hit_q.time_ps > tr_r) begin
          state_nxt = S_INS;
        end else begin
          hidx_nxt = hidx_r + 1'b1;
        end
      end

      S_INS: begin
        if (8'(cnt_q) >= lim) begin
          res_nxt.action = ACT_DROP;
          res_nxt.hits   = 5'(cnt_q);
          state_nxt      = S_DONE;
        end else begin
          kidx_nxt  = cnt_q;
          state_nxt = S_SHR;
        end
      end

      // move later hits up by one, then place the new hit
      S_SHR: begin
        if (kidx_r > hidx_r) begin
          state_nxt = S_SHW;
        end else begin
          hit_we         = 1'b1;
          cnt_we         = 1'b1;
          cnt_wd         = cnt_q + 1'b1;
          res_nxt.action = ACT_INSERT;
          res_nxt.hits   = 5'(cnt_q + 1'b1);
          state_nxt      = S_DONE;
        end
      end

      S_SHW: begin
        hit_we    = 1'b1;
        hit_wa    = hit_addr(ch_r, kidx_r);
        hit_wd    = hit_q;
        kidx_nxt  = kidx_r - 1'b1;
        state_nxt = S_SHR;
      end

      // hand the result to the output register
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = res_r.action;
          out_tdata_nxt  = {1'b0, res_r.rbg, res_r.rdep, res_r.renergy, res_r.rtime,
                            res_r.rvalid, res_r.hits, res_r.center, res_r.label,
                            res_r.slot};
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // hit store read address
  assign hit_ra = (state_r == S_SHR) ? hit_addr(ch_r, kidx_r - 1'b1)
                                     : hit_addr(ch_nxt, hidx_nxt);

  // memory ports, read data registered
  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
    tbl_q <= tbl_mem[ch_nxt];
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_q <= cnt_mem[ch_nxt];
    if (hit_we) hit_mem[hit_wa] <= hit_wd;
    hit_q <= hit_mem[hit_ra];
  end

  // control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      ch_r         <= '0;
      top_r        <= '0;
      bot_r        <= '1;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ch_r         <= ch_nxt;
      top_r        <= top_nxt;
      bot_r        <= bot_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    e_r         <= e_nxt;
    t_in_r      <= t_in_nxt;
    bg_r        <= bg_nxt;
    hs_r        <= hs_nxt;
    hidx_r      <= hidx_nxt;
    kidx_r      <= kidx_nxt;
    neg_r       <= neg_nxt;
    tq_r        <= tq_nxt;
    prod_r      <= prod_nxt;
    tr_r        <= tr_nxt;
    res_r       <= res_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // the clearing pass never touches the hit store
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == S_INIT || state_r == S_CLR) |-> !hit_we)
    else $error("hit store written during clearing pass");
  // a hit count never exceeds the list depth
  assert property (@(posedge clk) disable iff (!rst_n)
                   cnt_we |-> 32'(cnt_wd) <= HITS_PER_CHANNEL)
    else $error("hit count beyond list depth");
  // inserts only happen below the configured limit
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == S_SHR && cnt_we) |-> 8'(cnt_q) < lim)
    else $error("insert into full list");
  // the walk stays inside the table
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == S_WUP || state_r == S_WDN) |-> 32'(ch_r) < CHANNELS)
    else $error("window walk left the table");

endmodule
